### src/olad_pkg.sv
// ----------------------------------------------------------------------------
// olad_pkg: shared types for the ordered list block
// Request codes, result status codes and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package olad_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned ReqWidth    = 2;
  localparam int unsigned StatusWidth = 3;

  // request codes
  typedef enum logic [ReqWidth-1:0] {
    REQ_APPEND = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [StatusWidth-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_READ      = 3'd5
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    capture;      // latch incoming request
    logic    append;       // write value at tail, bump count
    logic    start_read;   // index to head, read head entry
    logic    advance;      // index up by one, read that entry
    logic    shift_wr;     // move current entry one place toward head
    logic    drop;         // count down by one
    logic    set_status;   // load pending status code
    status_e status_code;
    logic    emit_result;  // single result from pending status
    logic    emit_elem;    // read-out result from current entry
  } olad_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_e req;
    logic full;
    logic empty;
    logic match;
    logic at_tail;
    logic out_free;
  } olad_sts_t;

endpackage

### src/olad_if.sv
// ----------------------------------------------------------------------------
// olad_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface olad_req_if;
  logic                                    valid;
  logic                                    ready;
  logic [olad_pkg::ReqWidth-1:0]           req_type;
  logic signed [olad_pkg::ValueWidth-1:0]  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface olad_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic [olad_pkg::StatusWidth-1:0]        status;
  logic signed [olad_pkg::ValueWidth-1:0]  element;
  logic                                    last;

  modport source (output valid, output status, output element, output last, input ready);
  modport sink   (input valid, input status, input element, input last, output ready);
endinterface

### src/ordered_list_append_delete.sv
// Append: request latched, dispatch writes it at the tail unless full, then
// the result state registers the result. Delete: scan then shift, one entry
// a cycle (straight to the result state if empty). The next request is taken
// once the result is registered. Read-out: one entry per cycle from the
// single store read port; a stalled result stalls the stream and the input.
// Reset clears the entry count and control state; the store is not cleared.
// ----------------------------------------------------------------------------
// ordered_list_append_delete: bounded ordered list of signed 32-bit values
// Append at tail, delete first match keeping order, read out head to tail.
// ----------------------------------------------------------------------------
module ordered_list_append_delete #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  olad_req_if.sink          req_i,
  olad_rsp_if.source        rsp_o
);

  olad_pkg::olad_cmd_t cmd;
  olad_pkg::olad_sts_t sts;
  logic [$clog2(CAPACITY+1)-1:0] count;

  olad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  olad_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .value_i       (req_i.value),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .out_status_o  (rsp_o.status),
    .out_element_o (rsp_o.element),
    .out_last_o    (rsp_o.last),
    .count_o       (count)
  );

  // entry count never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= ($bits(count))'(CAPACITY))
    else $error("entry count above capacity");

  // only read-out results may be non-final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != olad_pkg::ST_READ) |-> rsp_o.last)
    else $error("non-final result outside read-out");

  // element is zero outside read-out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != olad_pkg::ST_READ) |-> rsp_o.element == '0)
    else $error("nonzero element on a status result");

  // no new request while a read-out is still streaming
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !(rsp_o.valid && !rsp_o.last))
    else $error("request taken mid read-out");

endmodule

### src/olad_ram.sv
// ----------------------------------------------------------------------------
// olad_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module olad_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/olad_dp.sv
// ----------------------------------------------------------------------------
// olad_dp: ordered list datapath
// Entry store, entry count, scan index, request latch and result register.
// ----------------------------------------------------------------------------
module olad_dp #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  olad_pkg::olad_cmd_t                    cmd_i,
  output olad_pkg::olad_sts_t                    sts_o,
  input  logic [olad_pkg::ReqWidth-1:0]          req_type_i,
  input  logic signed [olad_pkg::ValueWidth-1:0] value_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [olad_pkg::StatusWidth-1:0]       out_status_o,
  output logic signed [olad_pkg::ValueWidth-1:0] out_element_o,
  output logic                                   out_last_o,
  output logic [$clog2(CAPACITY+1)-1:0]          count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = olad_pkg::ValueWidth;

  olad_pkg::req_e    req_q;
  logic [VW-1:0]     value_q;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     idx_q, idx_d;
  olad_pkg::status_e status_q;

  logic                   out_valid_q;
  olad_pkg::status_e      out_status_q;
  logic [VW-1:0]          out_elem_q;
  logic                   out_last_q;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_wdata, ram_rdata;
  logic          out_free;

  // request latch, pending status
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= olad_pkg::req_e'(req_type_i);
      value_q <= value_i;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
  end

  // count and index
  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.drop) begin
      count_d = count_q - CW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.start_read) begin
      idx_d = '0;
    end else if (cmd_i.advance) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // entry store ports: tail append or move one place toward head
  assign ram_we    = cmd_i.append | cmd_i.shift_wr;
  assign ram_waddr = cmd_i.append ? count_q[AW-1:0] : idx_q - AW'(1);
  assign ram_wdata = cmd_i.append ? value_q : ram_rdata;
  assign ram_re    = cmd_i.start_read | cmd_i.advance;
  assign ram_raddr = idx_d;

  olad_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_result || cmd_i.emit_elem) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_elem) begin
      out_status_q <= olad_pkg::ST_READ;
      out_elem_q   <= ram_rdata;
      out_last_q   <= sts_o.at_tail;
    end else if (cmd_i.emit_result) begin
      out_status_q <= status_q;
      out_elem_q   <= '0;
      out_last_q   <= 1'b1;
    end
  end

  // status back to controller
  always_comb begin
    sts_o.req      = req_q;
    sts_o.full     = (count_q == CW'(CAPACITY));
    sts_o.empty    = (count_q == '0);
    sts_o.match    = (ram_rdata == value_q);
    sts_o.at_tail  = ((CW'(idx_q) + CW'(1)) == count_q);
    sts_o.out_free = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_element_o = out_elem_q;
  assign out_last_o    = out_last_q;
  assign count_o       = count_q;

endmodule

### src/olad_ctrl.sv
// ----------------------------------------------------------------------------
// olad_ctrl: ordered list controller
// One-hot state machine sequencing append, scan/shift delete and read-out.
// ----------------------------------------------------------------------------
module olad_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  olad_pkg::olad_sts_t sts_i,
  output olad_pkg::olad_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_SCAN     = 6'b000100,
    S_SHIFT    = 6'b001000,
    S_READ_OUT = 6'b010000,
    S_RESULT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.status_code = olad_pkg::ST_INSERTED;
    in_ready_o        = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (sts_i.req)
          olad_pkg::REQ_APPEND: begin
            cmd_o.set_status = 1'b1;
            if (sts_i.full) begin
              cmd_o.status_code = olad_pkg::ST_FULL;
            end else begin
              cmd_o.append      = 1'b1;
              cmd_o.status_code = olad_pkg::ST_INSERTED;
            end
            state_d = S_RESULT;
          end
          olad_pkg::REQ_DELETE, olad_pkg::REQ_READ: begin
            if (sts_i.empty) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = olad_pkg::ST_EMPTY;
              state_d           = S_RESULT;
            end else begin
              cmd_o.start_read = 1'b1;
              state_d = (sts_i.req == olad_pkg::REQ_DELETE) ? S_SCAN : S_READ_OUT;
            end
          end
          default: begin
            // unused code: no result
            state_d = S_IDLE;
          end
        endcase
      end

      // look for first match, one entry a cycle
      S_SCAN: begin
        if (sts_i.match) begin
          if (sts_i.at_tail) begin
            cmd_o.drop        = 1'b1;
            cmd_o.set_status  = 1'b1;
            cmd_o.status_code = olad_pkg::ST_DELETED;
            state_d           = S_RESULT;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_SHIFT;
          end
        end else if (sts_i.at_tail) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = olad_pkg::ST_NOT_FOUND;
          state_d           = S_RESULT;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end

      // close the gap, one entry a cycle
      S_SHIFT: begin
        cmd_o.shift_wr = 1'b1;
        if (sts_i.at_tail) begin
          cmd_o.drop        = 1'b1;
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = olad_pkg::ST_DELETED;
          state_d           = S_RESULT;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end

      // stream entries head to tail
      S_READ_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_elem = 1'b1;
          if (sts_i.at_tail) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end

      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_result = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
